// ===== hw/rtl/xerd_pkg.sv =====
// ----------------------------------------------------------------------------
// xerd_pkg - shared types and constants for the entity reference decoder
// Beat formats on the input, internal command queue and result channels,
// parser mode codes and the predefined entity name table.
// ----------------------------------------------------------------------------
package xerd_pkg;

  // input beat: one raw byte of the attribute value
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } xerd_in_t;

  // result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       run_last;
  } xerd_out_t;

  // command from front to back: what one input beat produces
  // nbytes == 0 is only queued for the last beat (bare end marker)
  typedef struct packed {
    logic [2:0]  nbytes;
    logic        is_cp;
    logic [7:0]  lit;
    logic [20:0] cp;
    logic        last;
  } xerd_cmd_t;

  // parser modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_AMP    = 3'd1;
  localparam logic [2:0] MODE_HASH   = 3'd2;
  localparam logic [2:0] MODE_XSEEN  = 3'd3;
  localparam logic [2:0] MODE_DIGITS = 3'd4;
  localparam logic [2:0] MODE_NAME   = 3'd5;
  localparam logic [2:0] MODE_SEMI   = 3'd6;

  // special characters
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  localparam int unsigned NUM_ENT = 5;

  // entity name text, character i in bits [8*i +: 8], zero padded
  function automatic logic [39:0] ent_text(input logic [2:0] k);
    logic [39:0] t;
    case (k)
      3'd0:    t = 40'h00_00_70_6D_61; // amp
      3'd1:    t = 40'h00_00_00_74_6C; // lt
      3'd2:    t = 40'h00_00_00_74_67; // gt
      3'd3:    t = 40'h00_74_6F_75_71; // quot
      3'd4:    t = 40'h00_73_6F_70_61; // apos
      default: t = 40'h0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] i);
    logic [39:0] sh;
    sh = ent_text(k) >> {i, 3'b000};
    return sh[7:0];
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0:    n = 3'd3;
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd2;
      3'd3:    n = 3'd4;
      3'd4:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ent_value(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0:    v = 8'h26;
      3'd1:    v = 8'h3C;
      3'd2:    v = 8'h3E;
      3'd3:    v = 8'h22;
      3'd4:    v = 8'h27;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // first n characters of names k and c agree
  function automatic logic ent_prefix_eq(input logic [2:0] k, input logic [2:0] c,
                                         input logic [2:0] n);
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < 5; i++) begin
      if ((3'(i) < n) && (ent_char(k, 3'(i)) != ent_char(c, 3'(i)))) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

endpackage

// ===== hw/rtl/xml_entity_reference_decoder.sv =====
// ----------------------------------------------------------------------------
// xml_entity_reference_decoder - attribute value entity/char reference decoder
// Passes bytes through, expands the five predefined entities and numeric
// references (decimal or #x hex) to UTF-8, halting on malformed input.
//
//   channel  handshake         payload
//   -------  ----------------  -------------------------------------------
//   in       in_push/in_full   in_data  : in_byte, in_last
//   out      out_pop/out_empty out_data : out_byte, byte_valid,
//                                         string_end, run_last
//
// One input beat is taken per cycle while the command queue has room; the
// parser state loop (digit multiply-add and name match) is a single combinational step.
// Each beat yields 0 to 4 result beats, sent one per cycle while out_pop is
// high, so a beat that expands to n bytes holds the result side for n pops;
// QUEUE_DEPTH commands can wait between the two sides. Results appear at the
// earliest in the cycle after their input beat. Synchronous reset, no sweep.
// ----------------------------------------------------------------------------
module xml_entity_reference_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  xerd_pkg::xerd_in_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output xerd_pkg::xerd_out_t out_data
);
  import xerd_pkg::*;

  logic      q_push, q_pop, q_full, q_empty;
  xerd_cmd_t q_cmd, head_cmd;

  assign in_full = q_full;

  xerd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  xerd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  xerd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/xerd_front.sv =====
// ----------------------------------------------------------------------------
// xerd_front - reference parser
// Consumes one input beat per cycle while the queue has room, tracks the
// reference parse state and issues one command per beat that yields output, or is the last, into the command queue.
// ----------------------------------------------------------------------------
module xerd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  xerd_pkg::xerd_in_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output xerd_pkg::xerd_cmd_t q_cmd
);
  import xerd_pkg::*;

  logic [2:0]  mode_r, mode_nxt;
  logic        hex_r, hex_nxt;
  logic [31:0] cp_r, cp_nxt;
  logic        have_r, have_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        halted_r, halted_nxt;

  logic        acc;
  logic [7:0]  b;
  logic        last;

  // digit decode and accumulate
  logic        dig_ok;
  logic [3:0]  dval;
  logic [35:0] cp_mul;
  logic [35:0] cp_sum;
  logic        ovf;

  // name match
  logic [2:0]  cur;
  logic [NUM_ENT-1:0] hit;
  logic        name_ok;
  logic [2:0]  name_k;
  logic [2:0]  pos_inc;

  logic        do_digit, do_name;
  logic        emit_lit, emit_cp;
  logic [7:0]  lit;
  logic [2:0]  cp_nb;

  assign acc  = in_push && !q_full;
  assign b    = in_data.in_byte;
  assign last = in_data.in_last;

  // digit of the current base
  always_comb begin
    dig_ok = 1'b0;
    dval   = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      dig_ok = 1'b1;
      dval   = b[3:0];
    end else if (hex_r && ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))) begin
      dig_ok = 1'b1;
      dval   = 4'(b[2:0] + 3'd1) + 4'd8;
    end
  end

  assign cp_mul = hex_r ? {cp_r, 4'b0000}
                        : ({1'b0, cp_r, 3'b000} + {3'b000, cp_r, 1'b0});
  assign cp_sum = cp_mul + {32'd0, dval};
  assign ovf    = |cp_sum[35:32];

  // candidate names that take this byte at this position
  assign cur     = (cand_r < 3'(NUM_ENT)) ? cand_r : 3'd0;
  assign pos_inc = pos_r + 3'd1;
  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      hit[k] = (3'(k) >= cur) && (ent_len(3'(k)) > pos_r) && (pos_r < 3'd5) &&
               (ent_char(3'(k), pos_r) == b) && ent_prefix_eq(3'(k), cur, pos_r);
    end
  end

  // lowest matching candidate
  always_comb begin
    name_ok = 1'b0;
    name_k  = 3'd0;
    for (int k = NUM_ENT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        name_ok = 1'b1;
        name_k  = 3'(k);
      end
    end
  end

  // parse step
  always_comb begin
    mode_nxt   = mode_r;
    hex_nxt    = hex_r;
    cp_nxt     = cp_r;
    have_nxt   = have_r;
    cand_nxt   = cand_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    do_digit   = 1'b0;
    do_name    = 1'b0;
    emit_lit   = 1'b0;
    emit_cp    = 1'b0;
    lit        = b;

    if (!halted_r) begin
      case (mode_r)
        MODE_NORMAL: begin
          if (b == CH_AMP) begin
            mode_nxt = MODE_AMP;
            hex_nxt  = 1'b0;
            cp_nxt   = 32'd0;
            have_nxt = 1'b0;
            cand_nxt = 3'd0;
            pos_nxt  = 3'd0;
          end else begin
            emit_lit = 1'b1;
          end
        end
        MODE_AMP: begin
          if (b == CH_HASH) mode_nxt = MODE_HASH;
          else do_name = 1'b1;
        end
        MODE_HASH: begin
          if (b == CH_X) begin
            hex_nxt  = 1'b1;
            mode_nxt = MODE_XSEEN;
          end else if (b == CH_PLUS) begin
            mode_nxt = MODE_DIGITS;
          end else begin
            do_digit = 1'b1;
          end
        end
        MODE_XSEEN: begin
          if (b == CH_PLUS) mode_nxt = MODE_DIGITS;
          else do_digit = 1'b1;
        end
        MODE_DIGITS: do_digit = 1'b1;
        MODE_NAME:   do_name = 1'b1;
        MODE_SEMI: begin
          if (b == CH_SEMI) mode_nxt = MODE_NORMAL;
          else halted_nxt = 1'b1;
        end
        default: halted_nxt = 1'b1;
      endcase
    end

    // digit run: accumulate, or close the run and expect ';'
    if (do_digit) begin
      mode_nxt = MODE_DIGITS;
      if (dig_ok) begin
        cp_nxt   = cp_sum[31:0];
        have_nxt = 1'b1;
        if (ovf) halted_nxt = 1'b1;
      end else if (!have_r) begin
        halted_nxt = 1'b1;
      end else begin
        emit_cp = 1'b1;
        if (b == CH_SEMI) mode_nxt = MODE_NORMAL;
        else halted_nxt = 1'b1;
      end
    end

    // entity name: advance along the matched candidate
    if (do_name) begin
      if (!name_ok) begin
        halted_nxt = 1'b1;
      end else begin
        cand_nxt = name_k;
        pos_nxt  = pos_inc;
        mode_nxt = MODE_NAME;
        if (pos_inc == ent_len(name_k)) begin
          emit_lit = 1'b1;
          lit      = ent_value(name_k);
          mode_nxt = MODE_SEMI;
        end
      end
    end

    // string ends inside a digit run: flush it
    if (last && !halted_nxt && mode_nxt == MODE_DIGITS && have_nxt) begin
      emit_cp = 1'b1;
    end
  end

  // UTF-8 length of the emitted code point
  always_comb begin
    if (cp_nxt == 32'd0 || cp_nxt[31:21] != 11'd0) cp_nb = 3'd0;
    else if (cp_nxt[20:7] == 14'd0)                cp_nb = 3'd1;
    else if (cp_nxt[20:11] == 10'd0)               cp_nb = 3'd2;
    else if (cp_nxt[20:16] == 5'd0)                cp_nb = 3'd3;
    else                                           cp_nb = 3'd4;
  end

  // command to the back end
  always_comb begin
    q_cmd.is_cp  = emit_cp;
    q_cmd.lit    = lit;
    q_cmd.cp     = cp_nxt[20:0];
    q_cmd.last   = last;
    if (emit_lit)     q_cmd.nbytes = 3'd1;
    else if (emit_cp) q_cmd.nbytes = cp_nb;
    else              q_cmd.nbytes = 3'd0;
  end

  assign q_push = acc && (q_cmd.nbytes != 3'd0 || last);

  // state registers; the last beat returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      hex_r    <= 1'b0;
      cp_r     <= 32'd0;
      have_r   <= 1'b0;
      cand_r   <= 3'd0;
      pos_r    <= 3'd0;
      halted_r <= 1'b0;
    end else if (acc) begin
      if (last) begin
        mode_r   <= MODE_NORMAL;
        hex_r    <= 1'b0;
        cp_r     <= 32'd0;
        have_r   <= 1'b0;
        cand_r   <= 3'd0;
        pos_r    <= 3'd0;
        halted_r <= 1'b0;
      end else begin
        mode_r   <= mode_nxt;
        hex_r    <= hex_nxt;
        cp_r     <= cp_nxt;
        have_r   <= have_nxt;
        cand_r   <= cand_nxt;
        pos_r    <= pos_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  // a halted parser only queues the end marker
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    acc && halted_r && !last |-> !q_push)
    else $error("halted parser queued a command");

  // the last beat always queues exactly one closing command
  a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last |-> q_push && q_cmd.last)
    else $error("last beat did not queue a command");

  // after the last beat the parser is back in pass-through
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last |=> mode_r == MODE_NORMAL && !halted_r && !have_r)
    else $error("parser state not cleared after last beat");
`endif

endmodule

// ===== hw/rtl/xerd_queue.sv =====
// ----------------------------------------------------------------------------
// xerd_queue - command queue between parser and emitter
// Small register FIFO; full and empty come from registered count only.
// ----------------------------------------------------------------------------
module xerd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  xerd_pkg::xerd_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output xerd_pkg::xerd_cmd_t head_cmd,
  output logic                empty
);
  import xerd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  xerd_cmd_t         mem_r [DEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rp_r];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wrap_inc(wp_r);
      if (do_pop)  rp_r <= wrap_inc(rp_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

`ifndef SYNTHESIS
  // fill count follows a push without a pop
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("queue count did not follow push");
`endif

endmodule

// ===== hw/rtl/xerd_back.sv =====
// ----------------------------------------------------------------------------
// xerd_back - result emitter
// Walks the head command one result beat at a time: a literal byte, the
// UTF-8 bytes of a code point, or a bare end marker.
// ----------------------------------------------------------------------------
module xerd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  xerd_pkg::xerd_cmd_t head_cmd,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output xerd_pkg::xerd_out_t out_data
);
  import xerd_pkg::*;

  logic [1:0] idx_r;
  logic       take;
  logic       final_beat;
  logic [7:0] enc;

  // byte idx of the UTF-8 form of a code point with nb bytes
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] nb,
                                           input logic [1:0] idx);
    logic [7:0] r;
    logic [2:0] lane;
    lane = nb - 3'(idx) - 3'd1;  // continuation groups still to follow
    r = 8'h00;
    if (nb == 3'd1) begin
      r = {1'b0, cp[6:0]};
    end else if (idx == 2'd0) begin
      case (nb)
        3'd2:    r = {3'b110, cp[10:6]};
        3'd3:    r = {4'b1110, cp[15:12]};
        3'd4:    r = {5'b11110, cp[20:18]};
        default: r = 8'h00;
      endcase
    end else begin
      case (lane)
        3'd0:    r = {2'b10, cp[5:0]};
        3'd1:    r = {2'b10, cp[11:6]};
        3'd2:    r = {2'b10, cp[17:12]};
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  assign enc        = head_cmd.is_cp ? utf8_byte(head_cmd.cp, head_cmd.nbytes, idx_r)
                                     : head_cmd.lit;
  assign final_beat = (head_cmd.nbytes == 3'd0) ||
                      ({1'b0, idx_r} == head_cmd.nbytes - 3'd1);

  // result beat
  assign out_empty           = q_empty;
  assign out_data.byte_valid = (head_cmd.nbytes != 3'd0);
  assign out_data.out_byte   = out_data.byte_valid ? enc : 8'h00;
  assign out_data.run_last   = final_beat;
  assign out_data.string_end = final_beat && head_cmd.last;

  assign take  = out_pop && !q_empty;
  assign q_pop = take && final_beat;

  // position inside the head command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (take) begin
      idx_r <= final_beat ? 2'd0 : idx_r + 2'd1;
    end
  end

`ifndef SYNTHESIS
  // the byte index never runs past the command's length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty && head_cmd.nbytes != 3'd0 |-> {1'b0, idx_r} < head_cmd.nbytes)
    else $error("emitter index beyond command length");

  // a fresh command always starts at its first byte
  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> idx_r == 2'd0)
    else $error("emitter index not cleared after command");
`endif

endmodule
